[hw/rtl/ycc420_pkg.sv]
// Shared constants, types and helpers for the RGB to YCbCr 4:2:0 converter.
// No dependencies.
package ycc420_pkg;

  // Default frame size limits handed to the top-level parameters.
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Widths fixed by the item fields.
  localparam int PIX_W       = 8;
  localparam int CHROMA_PAIR = 2 * PIX_W;
  localparam int LIDX_W      = 24;
  localparam int CIDX_W      = 22;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int SUM_W       = 16;

  // Register map.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_LUMA_MAX     = 2'd2,
    CFG_CHROMA_MAX   = 2'd3
  } cfg_idx_t;

  // Register reset values.
  localparam int          RST_FRAME_WIDTH  = 1920;
  localparam int          RST_FRAME_HEIGHT = 1080;
  localparam logic [7:0]  RST_LUMA_MAX     = 8'd235;
  localparam logic [7:0]  RST_CHROMA_MAX   = 8'd240;

  // BT.601 coefficients, 7 fractional bits. Negative terms kept as magnitudes.
  localparam logic [SUM_W-1:0] Y_R      = 16'd33;
  localparam logic [SUM_W-1:0] Y_G      = 16'd65;
  localparam logic [SUM_W-1:0] Y_B      = 16'd13;
  localparam logic [SUM_W-1:0] CB_R_NEG = 16'd19;
  localparam logic [SUM_W-1:0] CB_G_NEG = 16'd37;
  localparam logic [SUM_W-1:0] CB_B     = 16'd56;
  localparam logic [SUM_W-1:0] CR_R     = 16'd56;
  localparam logic [SUM_W-1:0] CR_G_NEG = 16'd47;
  localparam logic [SUM_W-1:0] CR_B_NEG = 16'd9;
  localparam int               FRAC_BITS = 7;
  // 128 << 7: keeps chroma sums non-negative before the shift.
  localparam logic [SUM_W-1:0] CHROMA_BIAS = 16'd16384;
  localparam logic [PIX_W-1:0] LUMA_OFFSET = 8'd16;
  localparam logic [PIX_W-1:0] CLAMP_LOW   = 8'd16;

  // Upper limit first, then the floor of 16.
  function automatic logic [PIX_W-1:0] clamp_range(input logic [PIX_W-1:0] v,
                                                   input logic [PIX_W-1:0] hi);
    logic [PIX_W-1:0] t;
    t = (v > hi) ? hi : v;
    return (t < CLAMP_LOW) ? CLAMP_LOW : t;
  endfunction

endpackage

[hw/rtl/rgb_to_ycbcr_420_converter.sv]
// Top level of the RGB to YCbCr 4:2:0 converter: counters, pipeline, averaging.
// Depends on ycc420_pkg, ycc420_csc and ycc420_line_store.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+----------------------------
//  in      | in_valid in_ready red green blue          | RGB pixel, raster order
//  out     | out_valid out_ready luma luma_index       | Y per pixel, chroma per
//          | chroma_valid cb_out cr_out chroma_index   | 2x2 or edge cluster
//          | frame_last                                |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data    | register write, always ready
//
// One item per clock while the output is not stalled; stage 2 feeds out_valid.
// The line store is read at accept, written as an even-row item leaves stage 1; the
// rate is set by its one read and one write port, at most one access each per item.
// Reset (rst, synchronous) clears counters, neighbor registers and valid bits;
// line store contents are not cleared. A stalled output holds the full stages behind
// it while empty stages still fill; in_ready drops only while every stage is full.
module rgb_to_ycbcr_420_converter #(
  parameter int MAX_WIDTH  = ycc420_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ycc420_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // pixel input
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ycc420_pkg::PIX_W-1:0]          red,
  input  logic [ycc420_pkg::PIX_W-1:0]          green,
  input  logic [ycc420_pkg::PIX_W-1:0]          blue,
  // result output
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ycc420_pkg::PIX_W-1:0]          luma,
  output logic [ycc420_pkg::LIDX_W-1:0]         luma_index,
  output logic                                  chroma_valid,
  output logic [ycc420_pkg::PIX_W-1:0]          cb_out,
  output logic [ycc420_pkg::PIX_W-1:0]          cr_out,
  output logic [ycc420_pkg::CIDX_W-1:0]         chroma_index,
  output logic                                  frame_last,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ycc420_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ycc420_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ycc420_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);       // column counter / line store address
  localparam int RW = $clog2(MAX_HEIGHT);      // row counter
  localparam int WW = $clog2(MAX_WIDTH + 1);   // effective width
  localparam int HW = $clog2(MAX_HEIGHT + 1);  // effective height
  localparam int RST_W  = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
  localparam int RST_H  = (RST_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_FRAME_HEIGHT;
  localparam int RST_HW = (RST_W + 1) / 2;

  // Position of a pixel within its frame and cluster.
  typedef struct packed {
    logic last_col;
    logic last_row;
    logic col_odd;
    logic row_odd;
  } pos_t;

  // ---------------- configuration ----------------
  // Sizes are stored already forced into 1..MAX, with the chroma stride.
  logic [WW-1:0]    eff_w;
  logic [WW-1:0]    half_w;
  logic [HW-1:0]    eff_h;
  logic [PIX_W-1:0] luma_max;
  logic [PIX_W-1:0] chroma_max;
  logic [WW-1:0]    new_w;
  logic [HW-1:0]    new_h;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data == '0) begin
      new_w = WW'(1);
      new_h = HW'(1);
    end else begin
      new_w = (32'(cfg_data) > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(cfg_data);
      new_h = (32'(cfg_data) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w      <= WW'(RST_W);
      half_w     <= WW'(RST_HW);
      eff_h      <= HW'(RST_H);
      luma_max   <= RST_LUMA_MAX;
      chroma_max <= RST_CHROMA_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH: begin
          eff_w  <= new_w;
          half_w <= WW'(({1'b0, new_w} + 1'b1) >> 1);
        end
        CFG_FRAME_HEIGHT: eff_h      <= new_h;
        CFG_LUMA_MAX:     luma_max   <= cfg_data[PIX_W-1:0];
        CFG_CHROMA_MAX:   chroma_max <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic v1, v2;
  logic out_free, s2_free, s1_move, s2_move, accept;

  assign out_free = !out_valid || out_ready;
  assign s2_move  = v2 && out_free;
  assign s2_free  = !v2 || out_free;
  assign s1_move  = v1 && s2_free;
  assign in_ready = !v1 || s2_free;
  assign accept   = in_valid && in_ready;

  // ---------------- stage 0: raster counters ----------------
  logic [CW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;
  pos_t          pos0;

  always_comb begin
    pos0.last_col = ((WW+1)'(col_cnt) + 1'b1) >= (WW+1)'(eff_w);
    pos0.last_row = ((HW+1)'(row_cnt) + 1'b1) >= (HW+1)'(eff_h);
    pos0.col_odd  = col_cnt[0];
    pos0.row_odd  = row_cnt[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (pos0.last_col) begin
        col_cnt <= '0;
        row_cnt <= pos0.last_row ? '0 : row_cnt + 1'b1;
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

  // ---------------- stage 1: conversion, line store read data ----------------
  logic [PIX_W-1:0]       s1_r, s1_g, s1_b;
  logic [CW-1:0]          s1_col;
  logic [RW-1:0]          s1_row;
  pos_t                   s1_pos;
  logic [PIX_W-1:0]       s1_y, s1_cb, s1_cr;
  logic [CHROMA_PAIR-1:0] s1_up;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r   <= red;
      s1_g   <= green;
      s1_b   <= blue;
      s1_col <= col_cnt;
      s1_row <= row_cnt;
      s1_pos <= pos0;
    end
  end

  ycc420_csc u_csc (
    .red        (s1_r),
    .green      (s1_g),
    .blue       (s1_b),
    .luma_max   (luma_max),
    .chroma_max (chroma_max),
    .y          (s1_y),
    .cb         (s1_cb),
    .cr         (s1_cr)
  );

  // Even rows leave their chroma for the odd row below.
  ycc420_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (s1_move && !s1_pos.row_odd),
    .wr_addr (s1_col),
    .wr_data ({s1_cb, s1_cr}),
    .rd_en   (accept),
    .rd_addr (col_cnt),
    .rd_data (s1_up)
  );

  // ---------------- stage 2: neighbors, index products ----------------
  logic [CHROMA_PAIR-1:0] left_chroma, up_left_chroma;
  logic [CHROMA_PAIR-1:0] s2_left, s2_up_left, s2_up;
  logic [PIX_W-1:0]       s2_y, s2_cb, s2_cr;
  logic [CW-1:0]          s2_col;
  pos_t                   s2_pos;
  logic [LIDX_W-1:0]      s2_lprod;
  logic [CIDX_W-1:0]      s2_cprod;

  // Previous pixel's own chroma and its line store word, in stream order.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_chroma    <= '0;
      up_left_chroma <= '0;
    end else if (s1_move) begin
      left_chroma    <= {s1_cb, s1_cr};
      up_left_chroma <= s1_up;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_y       <= s1_y;
      s2_cb      <= s1_cb;
      s2_cr      <= s1_cr;
      s2_up      <= s1_up;
      s2_left    <= left_chroma;
      s2_up_left <= up_left_chroma;
      s2_col     <= s1_col;
      s2_pos     <= s1_pos;
      s2_lprod   <= LIDX_W'(s1_row * eff_w);
      s2_cprod   <= CIDX_W'((s1_row >> 1) * half_w);
    end
  end

  // ---------------- output: cluster averaging ----------------
  logic             c_valid;
  logic [PIX_W-1:0] c_cb, c_cr;
  logic [PIX_W+1:0] sum_cb, sum_cr;

  always_comb begin
    c_valid = 1'b0;
    sum_cb  = '0;
    sum_cr  = '0;
    c_cb    = '0;
    c_cr    = '0;
    if (s2_pos.row_odd && s2_pos.col_odd) begin
      // full 2x2 cluster
      c_valid = 1'b1;
      sum_cb  = (PIX_W+2)'(s2_cb) + (PIX_W+2)'(s2_left[CHROMA_PAIR-1:PIX_W])
              + (PIX_W+2)'(s2_up[CHROMA_PAIR-1:PIX_W])
              + (PIX_W+2)'(s2_up_left[CHROMA_PAIR-1:PIX_W]);
      sum_cr  = (PIX_W+2)'(s2_cr) + (PIX_W+2)'(s2_left[PIX_W-1:0])
              + (PIX_W+2)'(s2_up[PIX_W-1:0]) + (PIX_W+2)'(s2_up_left[PIX_W-1:0]);
      c_cb    = PIX_W'(sum_cb >> 2);
      c_cr    = PIX_W'(sum_cr >> 2);
    end else if (s2_pos.last_row && s2_pos.col_odd) begin
      // odd bottom edge: horizontal pair
      c_valid = 1'b1;
      sum_cb  = (PIX_W+2)'(s2_cb) + (PIX_W+2)'(s2_left[CHROMA_PAIR-1:PIX_W]);
      sum_cr  = (PIX_W+2)'(s2_cr) + (PIX_W+2)'(s2_left[PIX_W-1:0]);
      c_cb    = PIX_W'(sum_cb >> 1);
      c_cr    = PIX_W'(sum_cr >> 1);
    end else if (s2_pos.last_col && s2_pos.row_odd) begin
      // odd right edge: vertical pair
      c_valid = 1'b1;
      sum_cb  = (PIX_W+2)'(s2_cb) + (PIX_W+2)'(s2_up[CHROMA_PAIR-1:PIX_W]);
      sum_cr  = (PIX_W+2)'(s2_cr) + (PIX_W+2)'(s2_up[PIX_W-1:0]);
      c_cb    = PIX_W'(sum_cb >> 1);
      c_cr    = PIX_W'(sum_cr >> 1);
    end else if (s2_pos.last_row && s2_pos.last_col) begin
      // remaining case is an even row and column: lone corner pixel
      c_valid = 1'b1;
      c_cb    = s2_cb;
      c_cr    = s2_cr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        v1 <= in_valid;
      end
      if (s2_free) begin
        v2 <= v1;
      end
      if (out_free) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      luma         <= s2_y;
      luma_index   <= s2_lprod + LIDX_W'(s2_col);
      chroma_valid <= c_valid;
      cb_out       <= c_cb;
      cr_out       <= c_cr;
      chroma_index <= c_valid ? s2_cprod + CIDX_W'(s2_col >> 1) : '0;
      frame_last   <= s2_pos.last_row && s2_pos.last_col;
    end
  end

endmodule

[hw/rtl/ycc420_line_store.sv]
// Previous-row chroma store: one write port, one registered read port.
// Same-edge write/read of one entry is forwarded. Uses ycc420_pkg.
module ycc420_line_store #(
  parameter int DEPTH = ycc420_pkg::DEF_MAX_WIDTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [AW-1:0]                       wr_addr,
  input  logic [ycc420_pkg::CHROMA_PAIR-1:0]  wr_data,
  input  logic                                rd_en,
  input  logic [AW-1:0]                       rd_addr,
  output logic [ycc420_pkg::CHROMA_PAIR-1:0]  rd_data
);
  import ycc420_pkg::*;

  logic [CHROMA_PAIR-1:0] mem [DEPTH];
  logic [CHROMA_PAIR-1:0] mem_q;
  logic [CHROMA_PAIR-1:0] fwd_data;
  logic                   fwd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // Read-before-write array: a write landing on the read entry at the same
  // edge is taken from the bypass register instead.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : mem_q;

endmodule

[hw/rtl/ycc420_csc.sv]
// Color space conversion of one pixel: RGB to clamped Y, Cb, Cr.
// Combinational; uses ycc420_pkg coefficients and clamp helper.
module ycc420_csc (
  input  logic [ycc420_pkg::PIX_W-1:0] red,
  input  logic [ycc420_pkg::PIX_W-1:0] green,
  input  logic [ycc420_pkg::PIX_W-1:0] blue,
  input  logic [ycc420_pkg::PIX_W-1:0] luma_max,
  input  logic [ycc420_pkg::PIX_W-1:0] chroma_max,
  output logic [ycc420_pkg::PIX_W-1:0] y,
  output logic [ycc420_pkg::PIX_W-1:0] cb,
  output logic [ycc420_pkg::PIX_W-1:0] cr
);
  import ycc420_pkg::*;

  logic [SUM_W-1:0] r16, g16, b16;
  logic [SUM_W-1:0] ysum, cbsum, crsum;
  logic [PIX_W-1:0] y_raw, cb_raw, cr_raw;

  always_comb begin
    r16   = SUM_W'(red);
    g16   = SUM_W'(green);
    b16   = SUM_W'(blue);
    ysum  = Y_R * r16 + Y_G * g16 + Y_B * b16;
    // Bias keeps these non-negative, so a logical shift equals the floor shift.
    cbsum = CHROMA_BIAS + CB_B * b16 - CB_R_NEG * r16 - CB_G_NEG * g16;
    crsum = CHROMA_BIAS + CR_R * r16 - CR_G_NEG * g16 - CR_B_NEG * b16;
    y_raw  = PIX_W'(ysum >> FRAC_BITS) + LUMA_OFFSET;
    cb_raw = PIX_W'(cbsum >> FRAC_BITS);
    cr_raw = PIX_W'(crsum >> FRAC_BITS);
    y  = clamp_range(y_raw, luma_max);
    cb = clamp_range(cb_raw, chroma_max);
    cr = clamp_range(cr_raw, chroma_max);
  end

endmodule

[verif/ycc420_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for rgb_to_ycbcr_420_converter: watches the pixel, result and register
// channels, predicts each result from its own copy of the state and compares fields.
// Depends on ycc420_pkg.
module ycc420_checker
  import ycc420_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [PIX_W-1:0]       red,
  input  logic [PIX_W-1:0]       green,
  input  logic [PIX_W-1:0]       blue,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [PIX_W-1:0]       luma,
  input  logic [LIDX_W-1:0]      luma_index,
  input  logic                   chroma_valid,
  input  logic [PIX_W-1:0]       cb_out,
  input  logic [PIX_W-1:0]       cr_out,
  input  logic [CIDX_W-1:0]      chroma_index,
  input  logic                   frame_last,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     errors,
  output int                     pending
);

  typedef struct packed {
    logic [PIX_W-1:0]  luma;
    logic [LIDX_W-1:0] luma_index;
    logic              chroma_valid;
    logic [PIX_W-1:0]  cb;
    logic [PIX_W-1:0]  cr;
    logic [CIDX_W-1:0] chroma_index;
    logic              frame_last;
  } ycc_result_t;

  logic [CFG_DATA_W-1:0]  width_reg, height_reg;
  logic [PIX_W-1:0]       luma_lim, chroma_lim;
  int                     col_pos, row_pos;
  logic [CHROMA_PAIR-1:0] left_pair, up_left_pair;
  logic [CHROMA_PAIR-1:0] line_pairs [MAX_WIDTH];
  ycc_result_t            results_q [$];

  // 0 acts as 1, anything past the maximum acts as the maximum
  function automatic int effective_size(input int v, input int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // upper limit first, then the floor of 16
  function automatic int limit_to(input int v, input int hi);
    int t;
    t = (v > hi) ? hi : v;
    return (t < 16) ? 16 : t;
  endfunction

  function automatic ycc_result_t convert_pixel(input int r, input int g, input int b);
    ycc_result_t            res;
    int                     w, h, cb, cr, avg_cb, avg_cr;
    bit                     last_col, last_row, col_odd, row_odd, hit;
    logic [CHROMA_PAIR-1:0] up;
    w        = effective_size(width_reg, MAX_WIDTH);
    h        = effective_size(height_reg, MAX_HEIGHT);
    last_col = col_pos + 1 >= w;
    last_row = row_pos + 1 >= h;
    col_odd  = col_pos[0];
    row_odd  = row_pos[0];
    // chroma sums carry a 128 << 7 bias so the shift stays on positive values
    res.luma = PIX_W'(limit_to(((33 * r + 65 * g + 13 * b) >> 7) + 16, luma_lim));
    cb = limit_to((16384 + 56 * b - 19 * r - 37 * g) >> 7, chroma_lim);
    cr = limit_to((16384 + 56 * r - 47 * g - 9 * b) >> 7, chroma_lim);
    up = (col_pos < MAX_WIDTH) ? line_pairs[col_pos] : '0;
    hit = 1'b1;
    avg_cb = 0;
    avg_cr = 0;
    if (row_odd && col_odd) begin
      avg_cb = (cb + left_pair[15:8] + up[15:8] + up_left_pair[15:8]) >> 2;
      avg_cr = (cr + left_pair[7:0] + up[7:0] + up_left_pair[7:0]) >> 2;
    end else if (last_row && col_odd) begin
      avg_cb = (cb + left_pair[15:8]) >> 1;
      avg_cr = (cr + left_pair[7:0]) >> 1;
    end else if (last_col && row_odd) begin
      avg_cb = (cb + up[15:8]) >> 1;
      avg_cr = (cr + up[7:0]) >> 1;
    end else if (last_row && last_col) begin
      // odd corner: single value passes
      avg_cb = cb;
      avg_cr = cr;
    end else begin
      hit = 1'b0;
    end
    res.luma_index   = LIDX_W'(row_pos * w + col_pos);
    res.chroma_valid = hit;
    res.cb           = PIX_W'(avg_cb);
    res.cr           = PIX_W'(avg_cr);
    res.chroma_index = hit ? CIDX_W'((row_pos >> 1) * ((w + 1) >> 1) + (col_pos >> 1)) : '0;
    res.frame_last   = last_row && last_col;

    if (!row_odd && col_pos < MAX_WIDTH) line_pairs[col_pos] = {cb[7:0], cr[7:0]};
    up_left_pair = up;
    left_pair    = {cb[7:0], cr[7:0]};
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return res;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      errors = errors + 1;
    end
  endtask

  task automatic check_result(input ycc_result_t got);
    ycc_result_t want;
    if (results_q.size() == 0) begin
      $display("%0t: unexpected result, luma %0d luma_index %0d", $time, got.luma,
               got.luma_index);
      errors = errors + 1;
    end else begin
      want = results_q.pop_front();
      compare_field("luma", want.luma, got.luma);
      compare_field("luma_index", want.luma_index, got.luma_index);
      compare_field("chroma_valid", want.chroma_valid, got.chroma_valid);
      compare_field("cb_out", want.cb, got.cb);
      compare_field("cr_out", want.cr, got.cr);
      compare_field("chroma_index", want.chroma_index, got.chroma_index);
      compare_field("frame_last", want.frame_last, got.frame_last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg    = CFG_DATA_W'(RST_FRAME_WIDTH);
      height_reg   = CFG_DATA_W'(RST_FRAME_HEIGHT);
      luma_lim     = RST_LUMA_MAX;
      chroma_lim   = RST_CHROMA_MAX;
      col_pos      = 0;
      row_pos      = 0;
      left_pair    = '0;
      up_left_pair = '0;
      foreach (line_pairs[i]) line_pairs[i] = '0;
      results_q.delete();
      errors       = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FRAME_WIDTH:  width_reg  = cfg_data;
          CFG_FRAME_HEIGHT: height_reg = cfg_data;
          CFG_LUMA_MAX:     luma_lim   = cfg_data[PIX_W-1:0];
          CFG_CHROMA_MAX:   chroma_lim = cfg_data[PIX_W-1:0];
          default: ;
        endcase
      end
      // older item leaves before a new one is predicted
      if (out_valid && out_ready)
        check_result({luma, luma_index, chroma_valid, cb_out, cr_out, chroma_index,
                      frame_last});
      if (in_valid && in_ready) results_q.push_back(convert_pixel(red, green, blue));
    end
    pending = results_q.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench top for rgb_to_ycbcr_420_converter: clock, reset, pixel and register
// stimulus, result back-pressure and the verdict. Depends on ycc420_pkg, the
// converter RTL and ycc420_checker.
module tb;
  import ycc420_pkg::*;

  localparam int CYCLE_LIMIT   = 400_000;
  localparam int RANDOM_PIXELS = 560;
  localparam int IDLE_PCT      = 32;
  localparam int HOLD_AT       = 24;    // results taken before the long output hold
  localparam int HOLD_CYCLES   = 200;

  // register select masks
  localparam logic [3:0] SEL_WIDTH  = 4'(1 << CFG_FRAME_WIDTH);
  localparam logic [3:0] SEL_HEIGHT = 4'(1 << CFG_FRAME_HEIGHT);
  localparam logic [3:0] SEL_LUMA   = 4'(1 << CFG_LUMA_MAX);
  localparam logic [3:0] SEL_CHROMA = 4'(1 << CFG_CHROMA_MAX);
  localparam logic [3:0] SEL_SIZE   = SEL_WIDTH | SEL_HEIGHT;
  localparam logic [3:0] SEL_ALL    = SEL_SIZE | SEL_LUMA | SEL_CHROMA;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   in_valid     = 1'b0;
  logic                   in_ready;
  logic [PIX_W-1:0]       red          = '0;
  logic [PIX_W-1:0]       green        = '0;
  logic [PIX_W-1:0]       blue         = '0;
  logic                   out_valid;
  logic                   out_ready    = 1'b0;
  logic [PIX_W-1:0]       luma;
  logic [LIDX_W-1:0]      luma_index;
  logic                   chroma_valid;
  logic [PIX_W-1:0]       cb_out;
  logic [PIX_W-1:0]       cr_out;
  logic [CIDX_W-1:0]      chroma_index;
  logic                   frame_last;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  int  errors;
  int  pending;
  int  pixels_sent   = 0;
  int  results_taken = 0;
  int  cycles        = 0;
  int  hold_left     = 0;
  bit  hold_done     = 1'b0;
  logic steady;

  // 100 MHz
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb_to_ycbcr_420_converter DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .luma         (luma),
    .luma_index   (luma_index),
    .chroma_valid (chroma_valid),
    .cb_out       (cb_out),
    .cr_out       (cr_out),
    .chroma_index (chroma_index),
    .frame_last   (frame_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  ycc420_checker result_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .luma         (luma),
    .luma_index   (luma_index),
    .chroma_valid (chroma_valid),
    .cb_out       (cb_out),
    .cr_out       (cr_out),
    .chroma_index (chroma_index),
    .frame_last   (frame_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending)
  );

  // No idling on either side for over a hundred items in the middle of the run.
  assign steady = (pixels_sent >= 300) && (pixels_sent < 420);

  // Run limit: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) results_taken <= results_taken + 1;
  end

  // Result side. Random stalls, plus one long hold while pixels keep coming so the
  // pipeline fills and in_ready has to drop.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_taken >= HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Extremes show up often so the clamps and the bias get exercised.
  function automatic logic [PIX_W-1:0] pick_level();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Offer one pixel, after a random gap, and hold it until taken. Leaves in_valid
  // high so back-to-back items never drop it within a step.
  task automatic send_pixel(input logic [PIX_W-1:0] r, g, b);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    red      <= r;
    green    <= g;
    blue     <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_pixel(pick_level(), pick_level(), pick_level());
    in_valid <= 1'b0;
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Clamp limits carry random upper bits; only the low byte is meant to stick.
  task automatic write_regs(input int w, h, luma_hi, chroma_hi, input logic [3:0] sel);
    if (sel[CFG_FRAME_WIDTH])  put_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
    if (sel[CFG_FRAME_HEIGHT]) put_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
    if (sel[CFG_LUMA_MAX])
      put_reg(CFG_LUMA_MAX, {5'($urandom_range(31)), 8'(luma_hi)});
    if (sel[CFG_CHROMA_MAX])
      put_reg(CFG_CHROMA_MAX, {5'($urandom_range(31)), 8'(chroma_hi)});
    cfg_valid <= 1'b0;
  endtask

  // Registers only change once every result is back and the pipe has emptied.
  // One edge first so the pending count includes the last accepted pixel.
  task automatic wait_idle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int w, h, fw, fh, count, sent_random;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset sizes (1920x1080), black, white, pure red and pure blue.
    send_pixel('0, '0, '0);
    send_pixel('1, '1, '1);
    send_pixel('1, '0, '0);
    send_pixel('0, '0, '1);
    in_valid <= 1'b0;
    wait_idle();

    // Width past the maximum acts as 4096, changed mid-row. One row per frame, so
    // this run writes line store entries 4..63 (0..3 came first), covering every
    // column the random frames below can read. The long output hold lands here.
    write_regs(8191, 1, 0, 0, SEL_SIZE);
    send_random(60);
    wait_idle();

    // Zero sizes act as 1x1: every pixel is its own corner cluster. Both clamp
    // limits below 16, so every value lands on 16.
    write_regs(0, 0, 0, 15, SEL_ALL);
    send_random(3);
    wait_idle();

    // 3x3 frame: odd right edge, odd bottom edge and odd corner.
    write_regs(3, 3, 255, 255, SEL_ALL);
    send_random(9);
    wait_idle();

    // Height past the maximum, then both sizes shrink mid-frame so the counters
    // sit beyond the new last column and then the new last row.
    write_regs(4, 8191, 128, 200, SEL_ALL);
    send_random(6);
    wait_idle();
    write_regs(2, 0, 0, 0, SEL_WIDTH);
    send_random(5);
    wait_idle();
    write_regs(0, 2, 0, 0, SEL_HEIGHT);
    send_random(3);
    wait_idle();

    // Random phases: mostly whole small frames, sometimes a partial run that
    // leaves the next size change landing mid-frame. Widths stay within the
    // line store entries written above.
    sent_random = 0;
    while (sent_random < RANDOM_PIXELS) begin
      case ($urandom_range(15))
        0:       w = 0;
        1, 2, 3: w = $urandom_range(48, 13);
        default: w = $urandom_range(12, 1);
      endcase
      case ($urandom_range(15))
        0:       h = 0;
        1:       h = $urandom_range(8191, DEF_MAX_HEIGHT + 1);
        2, 3:    h = $urandom_range(24, 9);
        default: h = $urandom_range(8, 1);
      endcase
      fw = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w);
      fh = (h == 0) ? 1 : ((h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h);
      write_regs(w, h,
                 ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(255, 16),
                 ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(255, 16),
                 (sent_random == 0) ? SEL_ALL : (SEL_SIZE | 4'($urandom_range(15))));
      if (fw * fh <= 96 && $urandom_range(3) != 0)
        count = fw * fh * $urandom_range(2, 1);
      else
        count = $urandom_range(40, 1);
      send_random(count);
      sent_random += count;
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
